// File: hdl/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared register codes, field widths and the configuration bundle of the
// glyph coverage blitter.
// ----------------------------------------------------------------------------
package gcb_pkg;

  // Field widths fixed by the register map and the item layout
  localparam int CovW       = 8;
  localparam int ColorW     = 32;
  localparam int OriginW    = 12;
  localparam int GlyphDimW  = 9;
  localparam int RasterDimW = 11;
  localparam int IndexW     = 20;
  localparam int CfgDataW   = 32;
  localparam int CfgIdxW    = 3;

  typedef logic [CfgIdxW-1:0] reg_idx_t;

  // Register indexes
  localparam reg_idx_t REG_TEXT_COLOR   = 3'd0;
  localparam reg_idx_t REG_ORIGIN_ROW   = 3'd1;
  localparam reg_idx_t REG_ORIGIN_COL   = 3'd2;
  localparam reg_idx_t REG_GLYPH_WIDTH  = 3'd3;
  localparam reg_idx_t REG_GLYPH_HEIGHT = 3'd4;
  localparam reg_idx_t REG_RASTER_ROWS  = 3'd5;
  localparam reg_idx_t REG_RASTER_COLS  = 3'd6;

  // Configuration bundle handed to the front and back ends
  typedef struct packed {
    logic        [ColorW-1:0]     text_color;
    logic signed [OriginW-1:0]    origin_row;
    logic signed [OriginW-1:0]    origin_col;
    logic        [GlyphDimW-1:0]  glyph_width;
    logic        [GlyphDimW-1:0]  glyph_height;
    logic        [RasterDimW-1:0] raster_rows;
    logic        [RasterDimW-1:0] raster_cols;
  } cfg_t;

endpackage

// File: hdl/gcb_front.sv
// ----------------------------------------------------------------------------
// gcb_front
// Accepts coverage beats, tracks the glyph row and column, places each pixel
// on the raster and forwards only visible, covered pixels to the queue.
// ----------------------------------------------------------------------------
module gcb_front #(
  parameter int MAX_RASTER_DIM = 1024,
  parameter int MAX_GLYPH_DIM  = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gcb_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [gcb_pkg::CovW-1:0]       in_coverage,
  output logic                           push,
  output logic [2*$clog2(MAX_RASTER_DIM)+gcb_pkg::CovW-1:0] push_data
);

  localparam int CW  = $clog2(MAX_GLYPH_DIM);
  localparam int GW  = (CW + 2 > gcb_pkg::GlyphDimW) ? CW + 2 : gcb_pkg::GlyphDimW;
  localparam int RW  = $clog2(MAX_RASTER_DIM);
  localparam int RDW = (RW + 1 > gcb_pkg::RasterDimW) ? RW + 1 : gcb_pkg::RasterDimW;
  localparam int PB0 = (CW + 1 > gcb_pkg::OriginW) ? CW + 1 : gcb_pkg::OriginW;
  localparam int PB  = (RDW > PB0) ? RDW : PB0;
  localparam int PW  = PB + 1;

  logic [CW-1:0]        row_r, row_nxt, col_r, col_nxt;
  logic [GW-1:0]        gw_raw, gh_raw, gw, gh;
  logic [RDW-1:0]       nr_raw, nc_raw, nr, nc;
  logic signed [PW-1:0] org_row, org_col, cnt_row, cnt_col, pos_row, pos_col;
  logic                 row_in, col_in, hit, accept, col_end, row_end;

  // Clamp glyph and raster sizes
  assign gw_raw = GW'(cfg.glyph_width);
  assign gh_raw = GW'(cfg.glyph_height);
  assign gw = (gw_raw == '0) ? GW'(1) :
              ((gw_raw > GW'(MAX_GLYPH_DIM)) ? GW'(MAX_GLYPH_DIM) : gw_raw);
  assign gh = (gh_raw == '0) ? GW'(1) :
              ((gh_raw > GW'(MAX_GLYPH_DIM)) ? GW'(MAX_GLYPH_DIM) : gh_raw);

  assign nr_raw = RDW'(cfg.raster_rows);
  assign nc_raw = RDW'(cfg.raster_cols);
  assign nr = (nr_raw > RDW'(MAX_RASTER_DIM)) ? RDW'(MAX_RASTER_DIM) : nr_raw;
  assign nc = (nc_raw > RDW'(MAX_RASTER_DIM)) ? RDW'(MAX_RASTER_DIM) : nc_raw;

  // Raster position of the current pixel
  assign org_row = PW'(cfg.origin_row);
  assign org_col = PW'(cfg.origin_col);
  assign cnt_row = $signed(PW'(row_r));
  assign cnt_col = $signed(PW'(col_r));
  assign pos_row = org_row + cnt_row;
  assign pos_col = org_col + cnt_col;

  // Classify: drop clipped or uncovered pixels
  assign row_in = !pos_row[PW-1] && (pos_row < $signed(PW'(nr)));
  assign col_in = !pos_col[PW-1] && (pos_col < $signed(PW'(nc)));
  assign hit    = row_in && col_in && (in_coverage != '0);

  assign accept    = in_valid && !in_stall;
  assign push      = accept && hit;
  assign push_data = {pos_row[RW-1:0], pos_col[RW-1:0], in_coverage};

  // Advance the glyph counters, wrapping at the clamped size
  assign col_end = (GW'(col_r) + GW'(1)) >= gw;
  assign row_end = (GW'(row_r) + GW'(1)) >= gh;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// File: hdl/gcb_queue.sv
// ----------------------------------------------------------------------------
// gcb_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module gcb_queue #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (AW+1)'(1);
      end
    end
  end

endmodule

// File: hdl/gcb_back.sv
// ----------------------------------------------------------------------------
// gcb_back
// Turns queued pixels into raster writes: multiplies out the row offset and
// the scaled alpha, then finishes the index and colour in the output stage.
// ----------------------------------------------------------------------------
module gcb_back #(
  parameter int MAX_RASTER_DIM = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gcb_pkg::cfg_t                     cfg,
  input  logic                              q_empty,
  input  logic [2*$clog2(MAX_RASTER_DIM)+gcb_pkg::CovW-1:0] q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gcb_pkg::IndexW-1:0]        out_raster_index,
  output logic [gcb_pkg::ColorW-1:0]        out_pixel_rgba
);

  localparam int RW  = $clog2(MAX_RASTER_DIM);
  localparam int RDW = (RW + 1 > gcb_pkg::RasterDimW) ? RW + 1 : gcb_pkg::RasterDimW;
  localparam int PRW = RW + RDW;
  localparam int SW  = ((PRW > gcb_pkg::IndexW) ? PRW : gcb_pkg::IndexW) + 1;
  localparam int AP  = 2 * gcb_pkg::CovW;

  logic [RDW-1:0]            nc_raw, nc;
  logic [RW-1:0]             q_row, q_col;
  logic [gcb_pkg::CovW-1:0]  q_cov;
  logic [PRW-1:0]            line_prod;
  logic [AP-1:0]             alpha_prod;

  logic                      s1_valid_r;
  logic [PRW-1:0]            s1_line_r;
  logic [RW-1:0]             s1_col_r;
  logic [AP-1:0]             s1_aprod_r;

  logic                      out_valid_r;
  logic [gcb_pkg::IndexW-1:0] out_index_r;
  logic [gcb_pkg::ColorW-1:0] out_rgba_r;

  logic                      out_adv, s1_adv;
  logic [AP:0]               div_sum;
  logic [gcb_pkg::CovW-1:0]  scaled;
  logic [SW-1:0]             idx_sum;

  // Row stride, clamped
  assign nc_raw = RDW'(cfg.raster_cols);
  assign nc = (nc_raw > RDW'(MAX_RASTER_DIM)) ? RDW'(MAX_RASTER_DIM) : nc_raw;

  // Unpack the queue entry
  assign q_row = q_data[2*RW+gcb_pkg::CovW-1 -: RW];
  assign q_col = q_data[gcb_pkg::CovW +: RW];
  assign q_cov = q_data[gcb_pkg::CovW-1:0];

  assign line_prod  = PRW'(q_row) * PRW'(nc);
  assign alpha_prod = AP'(cfg.text_color[31:24]) * AP'(q_cov);

  // Pipeline advance: a stage moves on when it is empty or its successor moves
  assign out_adv = !out_valid_r || !out_stall;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign q_pop   = !q_empty && s1_adv;

  // Divide by 255 via (x + (x >> 8) + 1) >> 8, exact for byte products
  assign div_sum = (AP+1)'(s1_aprod_r) + (AP+1)'(s1_aprod_r[AP-1:gcb_pkg::CovW])
                   + (AP+1)'(1);
  assign scaled  = div_sum[AP-1:gcb_pkg::CovW];
  assign idx_sum = SW'(s1_line_r) + SW'(s1_col_r);

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= q_pop;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_line_r  <= line_prod;
      s1_col_r   <= q_col;
      s1_aprod_r <= alpha_prod;
    end
    if (out_adv && s1_valid_r) begin
      out_index_r <= idx_sum[gcb_pkg::IndexW-1:0];
      out_rgba_r  <= {scaled, cfg.text_color[23:0]};
    end
  end

  assign out_valid        = out_valid_r;
  assign out_raster_index = out_index_r;
  assign out_pixel_rgba   = out_rgba_r;

endmodule

// File: hdl/glyph_coverage_blit.sv
// ----------------------------------------------------------------------------
// glyph_coverage_blit
// Places the coverage bytes of one glyph bitmap on a raster and emits one
// raster write per visible, covered pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Configure through cfg_we / cfg_index / cfg_wdata while the block is idle.
//   Feed coverage bytes in row-major glyph order on in_valid / in_stall; a
//   beat moves when valid is high and stall is low. Each beat yields zero or
//   one write on out_valid / out_stall: the linear raster index and the text
//   colour with its alpha scaled by coverage.
//   Path: the queue takes a beat at the edge on which it is accepted; the
//   multiply stage and then the output register each hold the item in
//   turn, and a receiver stall can hold it in either stage or the queue.
//   Throughput: one beat per cycle sustained while in_stall is low; the front
//   end and the two-stage back end each run at one item per cycle while out_stall is low.
//   Reset: glyph counters return to row 0, column 0, the queue and the back
//   end empty, and control registers reset; queue and stage data do not.
//   Receiver stall: the output register holds its write; the back end fills,
//   then the four-entry queue, after which in_stall rises. Beats that make no
//   write are still taken while the queue has room.
// ----------------------------------------------------------------------------
module glyph_coverage_blit #(
  parameter int MAX_RASTER_DIM = 1024,
  parameter int MAX_GLYPH_DIM  = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gcb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [gcb_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gcb_pkg::CovW-1:0]      in_coverage,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gcb_pkg::IndexW-1:0]    out_raster_index,
  output logic [gcb_pkg::ColorW-1:0]    out_pixel_rgba
);

  localparam int RW     = $clog2(MAX_RASTER_DIM);
  localparam int QW     = 2 * RW + gcb_pkg::CovW;
  localparam int QDEPTH = 4;

  gcb_pkg::cfg_t cfg_r, cfg_nxt;
  logic          push, q_pop, q_full, q_empty;
  logic [QW-1:0] push_data, q_data;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gcb_pkg::REG_TEXT_COLOR:   cfg_nxt.text_color   = cfg_wdata;
        gcb_pkg::REG_ORIGIN_ROW:   cfg_nxt.origin_row   = cfg_wdata[gcb_pkg::OriginW-1:0];
        gcb_pkg::REG_ORIGIN_COL:   cfg_nxt.origin_col   = cfg_wdata[gcb_pkg::OriginW-1:0];
        gcb_pkg::REG_GLYPH_WIDTH:  cfg_nxt.glyph_width  = cfg_wdata[gcb_pkg::GlyphDimW-1:0];
        gcb_pkg::REG_GLYPH_HEIGHT: cfg_nxt.glyph_height = cfg_wdata[gcb_pkg::GlyphDimW-1:0];
        gcb_pkg::REG_RASTER_ROWS:  cfg_nxt.raster_rows  = cfg_wdata[gcb_pkg::RasterDimW-1:0];
        gcb_pkg::REG_RASTER_COLS:  cfg_nxt.raster_cols  = cfg_wdata[gcb_pkg::RasterDimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_color   <= '0;
      cfg_r.origin_row   <= '0;
      cfg_r.origin_col   <= '0;
      cfg_r.glyph_width  <= gcb_pkg::GlyphDimW'(1);
      cfg_r.glyph_height <= gcb_pkg::GlyphDimW'(1);
      cfg_r.raster_rows  <= '0;
      cfg_r.raster_cols  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold the input off only when the queue has no room
  assign in_stall = q_full;

  gcb_front #(
    .MAX_RASTER_DIM (MAX_RASTER_DIM),
    .MAX_GLYPH_DIM  (MAX_GLYPH_DIM)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_coverage (in_coverage),
    .push        (push),
    .push_data   (push_data)
  );

  gcb_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  gcb_back #(
    .MAX_RASTER_DIM (MAX_RASTER_DIM)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_raster_index (out_raster_index),
    .out_pixel_rgba   (out_pixel_rgba)
  );

endmodule

// File: hdl/gcb_checker.sv
// ----------------------------------------------------------------------------
// gcb_checker
// Port-level checks of the glyph coverage blitter, bound to the top level.
// ----------------------------------------------------------------------------
module gcb_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gcb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [gcb_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [gcb_pkg::CovW-1:0]      in_coverage,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [gcb_pkg::IndexW-1:0]    out_raster_index,
  input  logic [gcb_pkg::ColorW-1:0]    out_pixel_rgba
);

  logic [gcb_pkg::ColorW-1:0] colour_r;

  // Track the last text colour written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r <= '0;
    end else if (cfg_we && (cfg_index == gcb_pkg::REG_TEXT_COLOR)) begin
      colour_r <= cfg_wdata;
    end
  end

  // Reset drops any pending write
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("write still valid after reset");

  // A stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_coverage))
    else $error("stalled input beat changed");

  // A stalled write holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_raster_index)
                               && $stable(out_pixel_rgba))
    else $error("stalled write changed");

  // Colour bytes pass through, alpha never exceeds the text alpha
  a_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_rgba[23:0] == colour_r[23:0])
                  && (out_pixel_rgba[31:24] <= colour_r[31:24]))
    else $error("written colour does not match text colour");

endmodule

bind glyph_coverage_blit gcb_checker u_gcb_checker (.*);
